// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mdpe_pkg.sv -----
// Types, constants, glyph table and state codes of the morphing digit pixel engine
package mdpe_pkg;

    // Parameter defaults
    localparam int MAX_POINTS_DEF  = 64;
    localparam int DIGIT_SLOTS_DEF = 4;
    localparam int GLYPH_ROWS_DEF  = 24;

    // Fixed sizes
    localparam int PT_W       = 8;
    localparam int GLYPH_COLS = 7;
    localparam int ROM_ROWS   = 24;
    localparam int DIGIT_MAX  = 9;

    // Arithmetic constants
    localparam logic [15:0] MORPH_MS    = 16'd800;
    localparam logic [9:0]  EASE_K      = 10'd765;
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam logic [7:0]  HUE_SPAN    = 8'd43;
    localparam logic [5:0]  VIS_ROWS    = 6'd23;
    localparam logic [7:0]  WIDTH_RESET = 8'd32;
    localparam logic [7:0]  FULL_T      = 8'd255;
    localparam logic [7:0]  CHAN_MAX    = 8'hFF;

    // Digit positions
    localparam logic [1:0] DI_HOUR_TENS  = 2'd0;
    localparam logic [1:0] DI_HOUR_UNITS = 2'd1;
    localparam logic [1:0] DI_MIN_TENS   = 2'd2;
    localparam logic [1:0] DI_MIN_UNITS  = 2'd3;

    typedef struct packed {
        logic [1:0]  digit_index;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [31:0] elapsed_ms;
        logic [6:0]  offset_x;
        logic [4:0]  offset_y;
    } in_item_t;

    typedef struct packed {
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic       visible;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_point;
    } out_item_t;

    // One point pair handed to the point unit
    typedef struct packed {
        logic [PT_W-1:0] from_pt;
        logic [PT_W-1:0] to_pt;
        logic            last;
    } pt_job_t;

    // Values that stay fixed over one item's points
    typedef struct packed {
        logic [7:0] ease;
        logic [6:0] offset_x;
        logic [4:0] offset_y;
        logic [7:0] hue0;
        logic [7:0] width;
    } pt_ctx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_SRC,
        ST_SCAN_DST,
        ST_T_DIV,
        ST_T_SQ,
        ST_T_EASE,
        ST_P_READ,
        ST_P_LAUNCH,
        ST_P_BUSY,
        ST_P_WAIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        SEC_RED,
        SEC_YELLOW,
        SEC_GREEN,
        SEC_CYAN,
        SEC_BLUE,
        SEC_MAGENTA
    } hue_sector_t;

    // Digit glyphs, 7 columns, bit 6 is the leftmost column
    localparam logic [6:0] GLYPH_ROM [10][ROM_ROWS] = '{
        '{7'h3E,7'h63,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,
          7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h63,7'h3E,7'h00,7'h00},
        '{7'h08,7'h18,7'h38,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,
          7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h1C,7'h3E,7'h00,7'h00,7'h00,7'h00},
        '{7'h3E,7'h63,7'h41,7'h01,7'h02,7'h04,7'h08,7'h10,7'h20,7'h40,7'h40,7'h40,
          7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h63,7'h7F,7'h00,7'h00,7'h00,7'h00},
        '{7'h3E,7'h63,7'h41,7'h01,7'h02,7'h04,7'h08,7'h1C,7'h02,7'h01,7'h01,7'h01,
          7'h01,7'h01,7'h01,7'h01,7'h41,7'h63,7'h3E,7'h00,7'h00,7'h00,7'h00,7'h00},
        '{7'h02,7'h06,7'h0A,7'h12,7'h22,7'h42,7'h42,7'h42,7'h7F,7'h02,7'h02,7'h02,
          7'h02,7'h02,7'h02,7'h02,7'h02,7'h02,7'h02,7'h00,7'h00,7'h00,7'h00,7'h00},
        '{7'h7F,7'h40,7'h40,7'h40,7'h7E,7'h03,7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,
          7'h01,7'h01,7'h01,7'h41,7'h63,7'h3E,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00},
        '{7'h1E,7'h20,7'h40,7'h40,7'h40,7'h7E,7'h63,7'h41,7'h41,7'h41,7'h41,7'h41,
          7'h41,7'h41,7'h41,7'h63,7'h3E,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00},
        '{7'h7F,7'h03,7'h02,7'h04,7'h08,7'h10,7'h20,7'h40,7'h40,7'h40,7'h40,7'h40,
          7'h40,7'h40,7'h40,7'h40,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00},
        '{7'h3E,7'h63,7'h41,7'h41,7'h63,7'h3E,7'h63,7'h41,7'h41,7'h41,7'h41,7'h41,
          7'h41,7'h41,7'h41,7'h63,7'h3E,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00},
        '{7'h3E,7'h63,7'h41,7'h41,7'h63,7'h3F,7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,
          7'h43,7'h62,7'h3C,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00}
    };

    // Row of a glyph; digits above nine show as nine, rows past the table are blank
    function automatic logic [6:0] glyph_row(input logic [3:0] digit, input logic [7:0] row);
        logic [3:0] d;
        logic [6:0] bits;
        d = (digit > 4'(DIGIT_MAX)) ? 4'(DIGIT_MAX) : digit;
        bits = '0;
        if (row < 8'(ROM_ROWS))
        begin
            bits = GLYPH_ROM[d][row[4:0]];
        end
        return bits;
    endfunction

endpackage

// ----- rtl/mdpe_point_unit.sv -----
// Point pipeline: ease interpolation, offset, visibility test and HSV colour
module mdpe_point_unit
    import mdpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  pt_job_t   job,
    input  pt_ctx_t   ctx,
    output logic      done,
    output out_item_t result
);

    // Stage 1 signals
    logic        [2:0]  from_c, to_c;
    logic        [4:0]  from_r, to_r;
    logic signed [3:0]  dcx;
    logic signed [5:0]  dry;
    logic signed [12:0] px;
    logic signed [14:0] py;
    logic        [4:0]  qx;
    logic        [6:0]  qy;
    logic        [8:0]  x_s;
    logic        [7:0]  y_s;

    logic       s1_vld_reg;
    logic [7:0] s1_x_reg;
    logic [5:0] s1_y_reg;
    logic       s1_vis_reg;
    logic       s1_last_reg;

    // Stage 2 signals
    logic [7:0]  hue;
    logic [7:0]  base;
    logic [7:0]  dif;
    logic [9:0]  rem6;
    hue_sector_t sec;

    logic        s2_vld_reg;
    logic [6:0]  s2_x_reg;
    logic [5:0]  s2_y_reg;
    logic        s2_vis_reg;
    logic        s2_last_reg;
    hue_sector_t s2_sec_reg;
    logic [7:0]  s2_rem_reg;

    // Stage 3 signals
    logic [15:0] q_prod, t_prod, vq_prod, vt_prod;
    logic [7:0]  q_fac, t_fac, vq, vt, v;
    logic [7:0]  red_c, green_c, blue_c;

    logic      res_vld_reg;
    out_item_t res_reg;

    // Interpolate and offset; the product's top bits give a floor shift by 8
    always_comb
    begin
        from_c = job.from_pt[2:0];
        to_c   = job.to_pt[2:0];
        from_r = job.from_pt[7:3];
        to_r   = job.to_pt[7:3];
        dcx    = $signed({1'b0, to_c}) - $signed({1'b0, from_c});
        dry    = $signed({1'b0, to_r}) - $signed({1'b0, from_r});
        px     = dcx * $signed({1'b0, ctx.ease});
        py     = dry * $signed({1'b0, ctx.ease});
        qx     = px[12:8];
        qy     = py[14:8];
        x_s    = {6'b0, from_c} + {{4{qx[4]}}, qx} + {2'b0, ctx.offset_x};
        y_s    = {3'b0, from_r} + {qy[6], qy} + {3'b0, ctx.offset_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= start;
            s2_vld_reg  <= s1_vld_reg;
            res_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_x_reg    <= x_s[7:0];
            s1_y_reg    <= y_s[5:0];
            s1_vis_reg  <= (x_s[7:0] < ctx.width) && (y_s[5:0] < VIS_ROWS);
            s1_last_reg <= job.last;
        end
    end

    // Hue from time and position, then sector and remainder
    always_comb
    begin
        hue = 8'(ctx.hue0 + {s1_x_reg[6:0], 1'b0} + s1_x_reg + {s1_y_reg, 2'b0}
                  + {2'b0, s1_y_reg});
        if (hue >= 8'(5 * HUE_SPAN))
        begin
            sec  = SEC_MAGENTA;
            base = 8'(5 * HUE_SPAN);
        end
        else if (hue >= 8'(4 * HUE_SPAN))
        begin
            sec  = SEC_BLUE;
            base = 8'(4 * HUE_SPAN);
        end
        else if (hue >= 8'(3 * HUE_SPAN))
        begin
            sec  = SEC_CYAN;
            base = 8'(3 * HUE_SPAN);
        end
        else if (hue >= 8'(2 * HUE_SPAN))
        begin
            sec  = SEC_GREEN;
            base = 8'(2 * HUE_SPAN);
        end
        else if (hue >= HUE_SPAN)
        begin
            sec  = SEC_YELLOW;
            base = HUE_SPAN;
        end
        else
        begin
            sec  = SEC_RED;
            base = 8'd0;
        end
        dif  = hue - base;
        rem6 = {dif, 2'b0} + {1'b0, dif, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            s2_x_reg    <= s1_x_reg[6:0];
            s2_y_reg    <= s1_y_reg;
            s2_vis_reg  <= s1_vis_reg;
            s2_last_reg <= s1_last_reg;
            s2_sec_reg  <= sec;
            s2_rem_reg  <= rem6[7:0];
        end
    end

    // Full-saturation HSV: the low channel is zero, value is the ease
    always_comb
    begin
        v       = ctx.ease;
        q_prod  = {s2_rem_reg, 8'b0} - {8'b0, s2_rem_reg};
        t_prod  = {CHAN_MAX - s2_rem_reg, 8'b0} - {8'b0, CHAN_MAX - s2_rem_reg};
        q_fac   = CHAN_MAX - q_prod[15:8];
        t_fac   = CHAN_MAX - t_prod[15:8];
        vq_prod = v * q_fac;
        vt_prod = v * t_fac;
        vq      = vq_prod[15:8];
        vt      = vt_prod[15:8];
        case (s2_sec_reg)
            SEC_RED:     begin red_c = v;    green_c = vt;   blue_c = 8'd0; end
            SEC_YELLOW:  begin red_c = vq;   green_c = v;    blue_c = 8'd0; end
            SEC_GREEN:   begin red_c = 8'd0; green_c = v;    blue_c = vt;   end
            SEC_CYAN:    begin red_c = 8'd0; green_c = vq;   blue_c = v;    end
            SEC_BLUE:    begin red_c = vt;   green_c = 8'd0; blue_c = v;    end
            default:     begin red_c = v;    green_c = 8'd0; blue_c = vq;   end
        endcase
        if (!s2_vis_reg)
        begin
            red_c   = 8'd0;
            green_c = 8'd0;
            blue_c  = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            res_reg.pixel_x    <= s2_x_reg;
            res_reg.pixel_y    <= s2_y_reg;
            res_reg.visible    <= s2_vis_reg;
            res_reg.red        <= red_c;
            res_reg.green      <= green_c;
            res_reg.blue       <= blue_c;
            res_reg.last_point <= s2_last_reg;
        end
    end

    assign done   = res_vld_reg;
    assign result = res_reg;

endmodule

// ----- rtl/morphing_digit_pixel_engine.sv -----
// Morphing clock digit pixel engine: one input item renders one digit as up to
// MAX_POINTS result items, one per glyph point. Slot state (shown and previous digit,
// morph start time, point counts) sits in a small synchronous slot memory and the
// scanned point lists in a point memory with one write and two read ports. An item
// that starts a morph, or the first item of a slot after reset, scans the glyph table
// at one cell a cycle, for a morph start the old glyph and then the new one. Ease
// set-up then runs through the divide, square and ease steps, and each point through
// the memory read, launch, three-stage point pipeline and output register, where it
// waits until the output is taken. One item is worked on at a time; a new item is
// taken once the last point has been taken.
module morphing_digit_pixel_engine
    import mdpe_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
    parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    `include "assert_macros.svh"

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
    localparam int RW = $clog2(GLYPH_ROWS);
    localparam int AW = SW + 1 + IW;
    localparam int PT_DEPTH = DIGIT_SLOTS * (2 ** (IW + 1));
    localparam logic LIST_SRC = 1'b0;
    localparam logic LIST_DST = 1'b1;

    typedef struct packed {
        logic [3:0]    shown;
        logic [3:0]    prev;
        logic [31:0]   ctime;
        logic          active;
        logic [CW-1:0] sc;
        logic [CW-1:0] dc;
    } slot_ent_t;

    ctl_state_t state_reg, state_next;

    logic [7:0]      width_reg;
    in_item_t        in_reg;
    logic [SW-1:0]   slot_reg;
    logic [SW-1:0]   slot_in;
    logic [DIGIT_SLOTS-1:0] slot_vld_reg;
    slot_ent_t       slot_mem [DIGIT_SLOTS];
    slot_ent_t       slot_rd_reg;
    slot_ent_t       ent_reg;
    logic            morph_reg;
    logic            full_t_reg;
    logic [9:0]      dt_reg;
    logic [3:0]      scan_dig_reg;
    logic [RW-1:0]   row_reg;
    logic [2:0]      col_reg;
    logic [CW-1:0]   n_reg;
    logic [7:0]      t_reg;
    logic [15:0]     sq_reg;
    logic [7:0]      e_reg;
    logic [CW-1:0]   i_reg;
    logic [CW-1:0]   count_reg;
    logic [IW-1:0]   is_reg;
    logic [IW-1:0]   id_reg;
    logic            out_valid_reg;
    out_item_t       out_reg;

    logic [PT_W-1:0] pt_mem [PT_DEPTH];
    logic [PT_W-1:0] pa_rd_reg, pb_rd_reg;

    // Decision signals
    slot_ent_t   ent_cur, ent_new;
    logic [3:0]  hour_q, min_q, want;
    logic [5:0]  hour_r, min_r;
    logic        start_morph, morph, ending;
    logic [15:0] dt16;
    logic [31:0] ctime_new;
    logic [3:0]  slot_tmp;

    // Scan and emission signals
    logic [6:0]    row_bits;
    logic          pt_bit, pt_we, scan_last;
    logic [CW-1:0] n_fin;
    logic [AW-1:0] pt_waddr, pa_addr, pb_addr;
    logic [25:0]   div_prod;
    logic [25:0]   ease_prod;
    logic [9:0]    ease_k;
    logic          pt_last;
    logic          unit_start, unit_done;
    pt_job_t       unit_job;
    pt_ctx_t       unit_ctx;
    out_item_t     unit_res;
    logic          out_take;

    // Tens digit of a value below 64
    function automatic logic [3:0] div10(input logic [5:0] val);
        logic [3:0] q;
        if (val >= 6'd60)      q = 4'd6;
        else if (val >= 6'd50) q = 4'd5;
        else if (val >= 6'd40) q = 4'd4;
        else if (val >= 6'd30) q = 4'd3;
        else if (val >= 6'd20) q = 4'd2;
        else if (val >= 6'd10) q = 4'd1;
        else                   q = 4'd0;
        return q;
    endfunction

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= WIDTH_RESET;
        else if (cfg_wr_en)
            width_reg <= cfg_wr_data;
    end

    // Slot of the incoming item: digit index wrapped to the slot count
    always_comb
    begin
        slot_tmp = {2'b0, in_data.digit_index};
        for (int k = 0; k < 3; k++)
        begin
            if (slot_tmp >= 4'(DIGIT_SLOTS))
                slot_tmp = slot_tmp - 4'(DIGIT_SLOTS);
        end
        slot_in = slot_tmp[SW-1:0];
    end

    // Wanted digit and morph decision for the slot just read
    always_comb
    begin
        ent_cur = slot_vld_reg[slot_reg] ? slot_rd_reg : '0;
        hour_q  = div10({1'b0, in_reg.hour});
        min_q   = div10(in_reg.minute);
        hour_r  = {1'b0, in_reg.hour} - 6'({hour_q, 3'b0} + {1'b0, hour_q, 1'b0});
        min_r   = in_reg.minute - 6'({min_q, 3'b0} + {1'b0, min_q, 1'b0});
        case (in_reg.digit_index)
            DI_HOUR_TENS:  want = hour_q;
            DI_HOUR_UNITS: want = hour_r[3:0];
            DI_MIN_TENS:   want = min_q;
            default:       want = min_r[3:0];
        endcase
        start_morph = (want != ent_cur.shown) && !ent_cur.active;
        morph       = start_morph || ent_cur.active;
        ctime_new   = start_morph ? in_reg.elapsed_ms : ent_cur.ctime;
        dt16        = 16'(in_reg.elapsed_ms - ctime_new);
        ending      = dt16 >= MORPH_MS;
        ent_new     = ent_cur;
        if (start_morph)
        begin
            ent_new.prev  = ent_cur.shown;
            ent_new.shown = want;
            ent_new.ctime = in_reg.elapsed_ms;
        end
        ent_new.active = morph && !ending;
    end

    // Glyph scan: one cell a cycle, lit cells go to the point memory up to MAX_POINTS per list
    always_comb
    begin
        row_bits  = glyph_row(scan_dig_reg, 8'(row_reg));
        pt_bit    = row_bits[3'(GLYPH_COLS - 1) - col_reg];
        pt_we     = ((state_reg == ST_SCAN_SRC) || (state_reg == ST_SCAN_DST))
                    && pt_bit && (n_reg < CW'(MAX_POINTS));
        n_fin     = pt_we ? n_reg + CW'(1) : n_reg;
        scan_last = (row_reg == RW'(GLYPH_ROWS - 1)) && (col_reg == 3'(GLYPH_COLS - 1));
        pt_waddr  = {slot_reg, (state_reg == ST_SCAN_DST) ? LIST_DST : LIST_SRC,
                     n_reg[IW-1:0]};
        pa_addr   = morph_reg ? {slot_reg, LIST_SRC, is_reg} : {slot_reg, LIST_DST, id_reg};
        pb_addr   = {slot_reg, LIST_DST, id_reg};
        div_prod  = {3'b0, dt_reg, 3'b0} * {13'b0, RECIP_25};
        ease_k    = EASE_K - {1'b0, t_reg, 1'b0};
        ease_prod = {10'b0, sq_reg} * {16'b0, ease_k};
        pt_last   = (i_reg + CW'(1)) == count_reg;
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_T_DIV)
            slot_mem[slot_reg] <= ent_reg;
        slot_rd_reg <= slot_mem[slot_in];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= {5'(row_reg), col_reg};
        pa_rd_reg <= pt_mem[pa_addr];
        pb_rd_reg <= pt_mem[pb_addr];
    end

    // Slot entries read as reset until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_vld_reg <= '0;
        else if (state_reg == ST_T_DIV)
            slot_vld_reg[slot_reg] <= 1'b1;
    end

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        unit_start = 1'b0;
        out_take   = out_valid_reg && out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (start_morph)
                    state_next = ST_SCAN_SRC;
                else if (!morph && (ent_cur.dc == '0))
                    state_next = ST_SCAN_DST;
                else
                    state_next = ST_T_DIV;
            end
            ST_SCAN_SRC:
                if (scan_last)
                    state_next = ST_SCAN_DST;
            ST_SCAN_DST:
                if (scan_last)
                    state_next = ST_T_DIV;
            ST_T_DIV:    state_next = ST_T_SQ;
            ST_T_SQ:     state_next = ST_T_EASE;
            ST_T_EASE:   state_next = ST_P_READ;
            ST_P_READ:   state_next = ST_P_LAUNCH;
            ST_P_LAUNCH:
            begin
                unit_start = 1'b1;
                state_next = ST_P_BUSY;
            end
            ST_P_BUSY:
                if (unit_done)
                    state_next = ST_P_WAIT;
            ST_P_WAIT:
                if (out_take)
                    state_next = out_reg.last_point ? ST_IDLE : ST_P_READ;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the item, run the scan counters, the ease chain and the point counters
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_reg   <= in_data;
                    slot_reg <= slot_in;
                end
            end
            ST_DECIDE:
            begin
                ent_reg      <= ent_new;
                morph_reg    <= morph;
                full_t_reg   <= !morph || ending;
                dt_reg       <= dt16[9:0];
                scan_dig_reg <= ent_cur.shown;
                row_reg      <= '0;
                col_reg      <= '0;
                n_reg        <= '0;
            end
            ST_SCAN_SRC, ST_SCAN_DST:
            begin
                n_reg <= n_fin;
                if (col_reg == 3'(GLYPH_COLS - 1))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                end
                if (scan_last)
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    n_reg   <= '0;
                    if (state_reg == ST_SCAN_SRC)
                    begin
                        ent_reg.sc   <= n_fin;
                        scan_dig_reg <= ent_reg.shown;
                    end
                    else
                    begin
                        ent_reg.dc <= n_fin;
                    end
                end
            end
            ST_T_DIV:
            begin
                t_reg     <= full_t_reg ? FULL_T : div_prod[24:17];
                count_reg <= (morph_reg && (ent_reg.sc > ent_reg.dc)) ? ent_reg.sc
                                                                      : ent_reg.dc;
                i_reg     <= '0;
                is_reg    <= '0;
                id_reg    <= '0;
            end
            ST_T_SQ:   sq_reg <= t_reg * t_reg;
            ST_T_EASE: e_reg  <= ease_prod[23:16];
            ST_P_WAIT:
            begin
                if (out_take)
                begin
                    i_reg  <= i_reg + CW'(1);
                    is_reg <= ((CW'(is_reg) + CW'(1)) == ent_reg.sc) ? '0 : is_reg + IW'(1);
                    id_reg <= ((CW'(id_reg) + CW'(1)) == ent_reg.dc) ? '0 : id_reg + IW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Point pipeline
    assign unit_job = '{from_pt: pa_rd_reg, to_pt: pb_rd_reg, last: pt_last};
    assign unit_ctx = '{ease: e_reg, offset_x: in_reg.offset_x, offset_y: in_reg.offset_y,
                        hue0: in_reg.elapsed_ms[11:4], width: width_reg};

    mdpe_point_unit u_point
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .job    (unit_job),
        .ctx    (unit_ctx),
        .done   (unit_done),
        .result (unit_res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_P_BUSY) && unit_done)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_P_BUSY) && unit_done)
            out_reg <= unit_res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    `ASSERT_NOW(a_idle_no_result, in_ready, !out_valid,
                "input taken while a result item is pending")
    `ASSERT_NEXT(a_last_frees_input, out_valid && out_ready && out_data.last_point,
                 in_ready, "engine not idle after the last point")
    `ASSERT_NOW(a_read_in_range, state_reg == ST_P_READ,
                (CW'(id_reg) < ent_reg.dc) && (!morph_reg || (CW'(is_reg) < ent_reg.sc)),
                "point read beyond the scanned list")
    `ASSERT_NOW(a_scan_in_range, pt_we, n_reg < CW'(MAX_POINTS),
                "point write beyond the list")

endmodule
